// ===== rtl/stcdj_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stcdj_pkg;

   localparam int AXIS_SLOTS          = 4;
   localparam int AXIS_COUNT_DEFAULT  = 4;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   localparam int FIELD_BITS    = 16;
   localparam int GAIN_BITS     = 16;
   localparam int DEADBAND_BITS = 15;
   localparam int JITTER_BITS   = 8;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] REG_GAIN_LEFT  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_GAIN_RIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_DEADBAND   = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_JITTER     = 2'd3;

   localparam logic [GAIN_BITS-1:0]     GAIN_RESET     = 16'd5243;
   localparam logic [DEADBAND_BITS-1:0] DEADBAND_RESET = 15'd143;
   localparam logic [JITTER_BITS-1:0]   JITTER_RESET   = 8'd4;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] left_x;
      logic signed [FIELD_BITS-1:0] left_y;
      logic signed [FIELD_BITS-1:0] right_x;
      logic signed [FIELD_BITS-1:0] right_y;
   } in_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] out_left_x;
      logic signed [FIELD_BITS-1:0] out_left_y;
      logic signed [FIELD_BITS-1:0] out_right_x;
      logic signed [FIELD_BITS-1:0] out_right_y;
   } out_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0]     gain_left;
      logic [GAIN_BITS-1:0]     gain_right;
      logic [DEADBAND_BITS-1:0] deadband;
      logic [JITTER_BITS-1:0]   jitter;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/stcdj_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stcdj_csr
   import stcdj_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                       cfg_o
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg_o     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_GAIN_LEFT: begin
               cfg_in.gain_left = csr_wdata[GAIN_BITS-1:0];
            end
            REG_GAIN_RIGHT: begin
               cfg_in.gain_right = csr_wdata[GAIN_BITS-1:0];
            end
            REG_DEADBAND: begin
               cfg_in.deadband = csr_wdata[DEADBAND_BITS-1:0];
            end
            REG_JITTER: begin
               cfg_in.jitter = csr_wdata[JITTER_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_left  <= GAIN_RESET;
         cfg_ff.gain_right <= GAIN_RESET;
         cfg_ff.deadband   <= DEADBAND_RESET;
         cfg_ff.jitter     <= JITTER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/stcdj_axis.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stcdj_axis
   import stcdj_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         update,
   input  wire logic                         primed,
   input  wire logic                         right_side,
   input  wire cfg_type                      cfg,
   input  wire logic signed [FIELD_BITS-1:0] a_i,
   input  wire logic signed [FIELD_BITS-1:0] b_i,
   output logic signed [FIELD_BITS-1:0]      held_o
);

   localparam int PROD_W = FIELD_BITS + GAIN_BITS + 1;
   localparam int NUM_W  = PROD_W + 2;
   localparam int Q_W    = NUM_W - GAIN_BITS;
   localparam int MAG_W  = FIELD_BITS + 1;
   localparam int DIFF_W = FIELD_BITS + 2;
   localparam logic signed [Q_W-1:0] SAT_HI = Q_W'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [Q_W-1:0] SAT_LO = -SAT_HI - Q_W'(1);

   logic        [GAIN_BITS-1:0]   gain;
   logic signed [FIELD_BITS:0]    a_ext;
   logic signed [FIELD_BITS:0]    a_sel;
   logic signed [PROD_W-1:0]      prod;
   logic signed [NUM_W-1:0]       num;
   logic                          round_up;
   logic signed [Q_W-1:0]         q_floor;
   logic signed [Q_W-1:0]         q;
   logic signed [SAMPLE_BITS-1:0] raw;
   logic signed [SAMPLE_BITS-1:0] base;
   logic signed [MAG_W-1:0]       raw_ext;
   logic        [MAG_W-1:0]       raw_mag;
   logic signed [DIFF_W-1:0]      diff;
   logic        [DIFF_W-1:0]      diff_mag;
   logic signed [SAMPLE_BITS-1:0] held_ff;
   logic signed [SAMPLE_BITS-1:0] held_in;

   assign gain  = right_side ? cfg.gain_right : cfg.gain_left;
   assign a_ext = {a_i[FIELD_BITS-1], a_i};
   assign a_sel = right_side ? -a_ext : a_ext;
   assign prod  = PROD_W'($signed({1'b0, gain})) * PROD_W'(b_i);
   assign num   = (NUM_W'(a_sel) <<< GAIN_BITS) - NUM_W'(prod);

   // truncate toward zero: floor, then step up for negative inexact values
   assign round_up = num[NUM_W-1] & (|num[GAIN_BITS-1:0]);
   assign q_floor  = Q_W'(num >>> GAIN_BITS);
   assign q        = q_floor + $signed({{(Q_W-1){1'b0}}, round_up});

   always_comb begin
      if (q > SAT_HI) begin
         raw = SAT_HI[SAMPLE_BITS-1:0];
      end else if (q < SAT_LO) begin
         raw = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         raw = q[SAMPLE_BITS-1:0];
      end
   end

   assign base     = primed ? held_ff : raw;
   assign raw_ext  = MAG_W'(raw);
   assign raw_mag  = raw_ext[MAG_W-1] ? MAG_W'(-raw_ext) : MAG_W'(raw_ext);
   assign diff     = DIFF_W'(raw) - DIFF_W'(base);
   assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

   always_comb begin
      if (raw_mag < MAG_W'(cfg.deadband)) begin
         held_in = '0;
      end else if (diff_mag > DIFF_W'(cfg.jitter)) begin
         held_in = raw;
      end else begin
         held_in = base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (update) begin
         held_ff <= held_in;
      end
   end

   assign held_o = FIELD_BITS'(held_ff);

endmodule

`default_nettype wire

// ===== rtl/stick_crosstalk_deadband_jitter_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake            | word
// req     | in        | req_valid/req_ready  | in_type: four raw hall readings
// rsp     | out       | rsp_valid/rsp_ready  | out_type: four held axis values
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One word a cycle unless rsp stalls; rsp valid follows the input register.
// Input register, then one pass through the per-axis multiply, saturate,
// deadband and hold compare; the held registers are the result register.
// Reset restores register defaults, clears the held values and the primed flag.
// A stalled rsp holds the held values; req keeps accepting until the input
// register is also full.

module stick_crosstalk_deadband_jitter_filter
   import stcdj_pkg::*;
#(
   parameter int AXIS_COUNT  = AXIS_COUNT_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire in_type                   req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output out_type                       rsp_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type cfg;
   in_type  s1_data_ff;
   logic    s1_valid_ff;
   logic    s1_valid_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   logic    primed_ff;
   logic    out_free;
   logic    advance;

   logic signed [FIELD_BITS-1:0] axis_a    [AXIS_SLOTS];
   logic signed [FIELD_BITS-1:0] axis_b    [AXIS_SLOTS];
   logic signed [FIELD_BITS-1:0] axis_held [AXIS_SLOTS];

   stcdj_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg_o     (cfg)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         primed_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         primed_ff    <= primed_ff || advance;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
   end

   // each axis is corrected against the other axis of the same stick
   assign axis_a[0] = s1_data_ff.left_x;
   assign axis_b[0] = s1_data_ff.left_y;
   assign axis_a[1] = s1_data_ff.left_y;
   assign axis_b[1] = s1_data_ff.left_x;
   assign axis_a[2] = s1_data_ff.right_x;
   assign axis_b[2] = s1_data_ff.right_y;
   assign axis_a[3] = s1_data_ff.right_y;
   assign axis_b[3] = s1_data_ff.right_x;

   for (genvar i = 0; i < AXIS_SLOTS; i++) begin : g_slot
      if (i < AXIS_COUNT) begin : g_axis
         stcdj_axis #(
            .SAMPLE_BITS (SAMPLE_BITS)
         ) u_axis (
            .clock      (clock),
            .reset      (reset),
            .update     (advance),
            .primed     (primed_ff),
            .right_side ((i >= AXIS_SLOTS / 2) ? 1'b1 : 1'b0),
            .cfg        (cfg),
            .a_i        (axis_a[i]),
            .b_i        (axis_b[i]),
            .held_o     (axis_held[i])
         );
      end else begin : g_unused
         assign axis_held[i] = '0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data.out_left_x  = axis_held[0];
   assign rsp_data.out_left_y  = axis_held[1];
   assign rsp_data.out_right_x = axis_held[2];
   assign rsp_data.out_right_y = axis_held[3];

   a_primed_sticks: assert property (@(posedge clock) disable iff (reset)
      primed_ff |=> primed_ff)
      else $error("primed flag dropped");

   a_rsp_after_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> primed_ff)
      else $error("result shown before first word processed");

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && primed_ff)
      else $error("processed word not presented");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input accepted with both registers full");

endmodule

`default_nettype wire
